// File: sv/cksb_pkg.sv
// Shared constants, codes and types of the color-keyed sprite blitter.
package cksb_pkg;

	localparam int MAX_SPRITES = 8;
	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 128;

	localparam int IDX_W  = $clog2(MAX_SPRITES);
	localparam int CNT_W  = $clog2(MAX_SPRITES + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W  = $clog2(MAXD + 1);
	localparam int ADDR_W = IDX_W + ROW_W + COL_W;
	// signed width for the setup arithmetic (9 bit fields plus growth)
	localparam int CW     = ((DIM_W > 9) ? DIM_W : 9) + 3;

	localparam logic [15:0] KEY_COLOR = 16'hDEAD;

	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_CLEAR = 3'd1;
	localparam logic [2:0] MODE_FILL  = 3'd2;
	localparam logic [2:0] MODE_BLIT  = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0] x0;
		logic [DIM_W-1:0] y0;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic start;
		logic step;
	} walk_ctl_t;

	typedef struct packed {
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             last;
		logic             empty;
	} walk_pos_t;

endpackage

// File: sv/cksb_pixmem.sv
// Pixel store: one write port, one read port with registered data.
module cksb_pixmem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [cksb_pkg::ADDR_W-1:0] waddr,
	input  logic [15:0]                wdata,
	input  logic [cksb_pkg::ADDR_W-1:0] raddr,
	output logic [15:0]                rdata
);

	logic [15:0] mem [(1 << cksb_pkg::ADDR_W)];
	logic [15:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/cksb_walker.sv
// Rectangle walker: steps column by column, row by row over a rectangle.
module cksb_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  cksb_pkg::walk_ctl_t ctl,
	input  cksb_pkg::rect_t     rect,
	output cksb_pkg::walk_pos_t pos
);

	logic [cksb_pkg::DIM_W-1:0] x0_q, w_q, col_q, row_q, ccnt_q, rcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q   <= '0;
			w_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
			ccnt_q <= '0;
			rcnt_q <= '0;
		end else if (ctl.start) begin
			x0_q   <= rect.x0;
			w_q    <= rect.w;
			col_q  <= rect.x0;
			row_q  <= rect.y0;
			ccnt_q <= rect.w;
			rcnt_q <= rect.h;
		end else if (ctl.step) begin
			// wrap to next row at end of a row
			if (ccnt_q == cksb_pkg::DIM_W'(1)) begin
				col_q  <= x0_q;
				ccnt_q <= w_q;
				row_q  <= row_q + cksb_pkg::DIM_W'(1);
				rcnt_q <= rcnt_q - cksb_pkg::DIM_W'(1);
			end else begin
				col_q  <= col_q + cksb_pkg::DIM_W'(1);
				ccnt_q <= ccnt_q - cksb_pkg::DIM_W'(1);
			end
		end
	end

	assign pos.col   = col_q;
	assign pos.row   = row_q;
	assign pos.last  = (ccnt_q == cksb_pkg::DIM_W'(1)) && (rcnt_q == cksb_pkg::DIM_W'(1));
	assign pos.empty = (ccnt_q == '0) || (rcnt_q == '0);

endmodule

// File: sv/color_keyed_sprite_blitter_top.sv
// Color-keyed sprite blitter: one command per transaction, sequenced over a pixel walker.
// Sequence: accept, load target size, load source size, calculate, then the result; a read in
// range also waits for the registered pixel, a paint adds a start and a run state per rectangle
// (three for a fill), and a blit adds a start state and a read and a write state per pixel.
// One transaction at a time: the next command is accepted only after the result has been taken.
// Reset clears sizes and count; pixels are painted on add and grow.
module color_keyed_sprite_blitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  target_sprite,
	input  logic [2:0]  source_sprite,
	input  logic [8:0]  pos_x,
	input  logic [8:0]  pos_y,
	input  logic [8:0]  rect_w,
	input  logic [8:0]  rect_h,
	input  logic [15:0] color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] value,
	output logic [3:0]  sprite_count
);

	localparam int DW = cksb_pkg::DIM_W;
	localparam int CW = cksb_pkg::CW;
	localparam logic [1:0] PH_USER = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_TDIM, S_SDIM, S_CALC, S_PSTART, S_PRUN,
		S_BSTART, S_BRD, S_BWR, S_RWAIT, S_OUT
	} state_t;

	state_t state_q;

	logic [2:0]  mode_q, tgt_q, src_q;
	logic [8:0]  px_q, py_q, pw_q, ph_q;
	logic [15:0] color_q;
	logic [DW-1:0] tw_q, th_q, sw_q, sh_q;
	logic [DW-1:0] width_q  [cksb_pkg::MAX_SPRITES];
	logic [DW-1:0] height_q [cksb_pkg::MAX_SPRITES];
	logic [cksb_pkg::CNT_W-1:0] cnt_q;
	logic [1:0]  status_q;
	logic [15:0] value_q;
	logic [1:0]  phase_q, phase_last_q;
	logic        fill_q;
	logic [cksb_pkg::IDX_W-1:0] psprite_q;
	cksb_pkg::rect_t rect0_q, rect1_q, rect2_q;

	// walker and memory hookup
	cksb_pkg::walk_ctl_t wctl;
	cksb_pkg::walk_pos_t wpos;
	cksb_pkg::rect_t     wrect;
	logic        we;
	logic [cksb_pkg::ADDR_W-1:0] waddr, raddr;
	logic [15:0] wdata, rdata;

	cksb_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.rect   (wrect),
		.pos    (wpos)
	);

	cksb_pixmem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// setup arithmetic, evaluated in S_CALC from registered fields
	logic signed [CW-1:0] x, y, w, h, tw, th, sw, sh, mw, mh;
	logic signed [CW-1:0] aw, ah, xc, yc, wv, hv, ew, eh, nw, nh;
	logic signed [CW-1:0] r0, c0, r1, c1, nr, nc;
	logic add_sat, fill_sat, bad_t, bad_s, in_rng;
	logic [cksb_pkg::ADDR_W-1:0] pix_addr, bsrc_addr, btgt_addr;

	always_comb begin
		x  = {{(CW-9){px_q[8]}}, px_q};
		y  = {{(CW-9){py_q[8]}}, py_q};
		w  = {{(CW-9){pw_q[8]}}, pw_q};
		h  = {{(CW-9){ph_q[8]}}, ph_q};
		tw = {{(CW-DW){1'b0}}, tw_q};
		th = {{(CW-DW){1'b0}}, th_q};
		sw = {{(CW-DW){1'b0}}, sw_q};
		sh = {{(CW-DW){1'b0}}, sh_q};
		mw = CW'(cksb_pkg::MAX_WIDTH);
		mh = CW'(cksb_pkg::MAX_HEIGHT);

		// add: negative to zero, clamp to maximum
		aw = (w < 0) ? '0 : w;
		ah = (h < 0) ? '0 : h;
		add_sat = (aw > mw) || (ah > mh);
		if (aw > mw) aw = mw;
		if (ah > mh) ah = mh;

		// fill: clamp origin, resolve sizes, grow with saturation
		xc = (x < 0) ? '0 : ((x > tw) ? tw : x);
		yc = (y < 0) ? '0 : ((y > th) ? th : y);
		wv = (w == -1) ? (tw - xc) : ((w < 0) ? '0 : w);
		hv = (h == -1) ? (th - yc) : ((h < 0) ? '0 : h);
		ew = xc + wv;
		eh = yc + hv;
		nw = (ew > tw) ? ew : tw;
		nh = (eh > th) ? eh : th;
		fill_sat = (nw > mw) || (nh > mh);
		if (nw > mw) nw = mw;
		if (nh > mh) nh = mh;
		if (ew > nw) wv = nw - xc;
		if (eh > nh) hv = nh - yc;

		// blit: clip source against destination
		r0 = (y < 0) ? -y : '0;
		c0 = (x < 0) ? -x : '0;
		r1 = ((sh + y) > th) ? (th - y) : sh;
		c1 = ((sw + x) > tw) ? (tw - x) : sw;
		nr = (r1 > r0) ? (r1 - r0) : '0;
		nc = (c1 > c0) ? (c1 - c0) : '0;

		bad_t  = {1'b0, tgt_q} >= cnt_q;
		bad_s  = {1'b0, src_q} >= cnt_q;
		in_rng = (x >= 0) && (y >= 0) && (x < tw) && (y < th);

		pix_addr  = {tgt_q, py_q[cksb_pkg::ROW_W-1:0], px_q[cksb_pkg::COL_W-1:0]};
		bsrc_addr = {src_q, wpos.row[cksb_pkg::ROW_W-1:0], wpos.col[cksb_pkg::COL_W-1:0]};
		btgt_addr = {tgt_q,
			py_q[cksb_pkg::ROW_W-1:0] + wpos.row[cksb_pkg::ROW_W-1:0],
			px_q[cksb_pkg::COL_W-1:0] + wpos.col[cksb_pkg::COL_W-1:0]};
	end

	// walker control and pixel port muxing
	always_comb begin
		wctl.start = (state_q == S_PSTART) || (state_q == S_BSTART);
		wctl.step  = ((state_q == S_PRUN) && !wpos.empty && !wpos.last) ||
			((state_q == S_BWR) && !wpos.last);
		case (phase_q)
			2'd0:    wrect = rect0_q;
			2'd1:    wrect = rect1_q;
			default: wrect = rect2_q;
		endcase
		raddr = (state_q == S_CALC) ? pix_addr : bsrc_addr;
		we    = ((state_q == S_PRUN) && !wpos.empty) ||
			((state_q == S_BWR) && (rdata != cksb_pkg::KEY_COLOR));
		if (state_q == S_PRUN) begin
			waddr = {psprite_q, wpos.row[cksb_pkg::ROW_W-1:0], wpos.col[cksb_pkg::COL_W-1:0]};
			wdata = (fill_q && (phase_q == PH_USER)) ? color_q : cksb_pkg::KEY_COLOR;
		end else begin
			waddr = btgt_addr;
			wdata = rdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			status_q     <= cksb_pkg::ST_OK;
			value_q      <= '0;
			phase_q      <= '0;
			phase_last_q <= '0;
			fill_q       <= 1'b0;
			psprite_q    <= '0;
			mode_q <= '0; tgt_q <= '0; src_q <= '0;
			px_q <= '0; py_q <= '0; pw_q <= '0; ph_q <= '0; color_q <= '0;
			tw_q <= '0; th_q <= '0; sw_q <= '0; sh_q <= '0;
			rect0_q <= '0; rect1_q <= '0; rect2_q <= '0;
			for (int i = 0; i < cksb_pkg::MAX_SPRITES; i++) begin
				width_q[i]  <= '0;
				height_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						tgt_q    <= target_sprite;
						src_q    <= source_sprite;
						px_q     <= pos_x;
						py_q     <= pos_y;
						pw_q     <= rect_w;
						ph_q     <= rect_h;
						color_q  <= color;
						status_q <= cksb_pkg::ST_OK;
						value_q  <= '0;
						phase_q  <= '0;
						state_q  <= S_TDIM;
					end
				end
				S_TDIM: begin
					tw_q    <= width_q[tgt_q];
					th_q    <= height_q[tgt_q];
					state_q <= S_SDIM;
				end
				S_SDIM: begin
					sw_q    <= width_q[src_q];
					sh_q    <= height_q[src_q];
					state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= S_OUT;
					case (mode_q)
						cksb_pkg::MODE_ADD: begin
							if (cnt_q >= cksb_pkg::CNT_W'(cksb_pkg::MAX_SPRITES)) begin
								status_q <= cksb_pkg::ST_FULL;
							end else begin
								if (add_sat) status_q <= cksb_pkg::ST_SAT;
								width_q[cnt_q[cksb_pkg::IDX_W-1:0]]  <= DW'(aw);
								height_q[cnt_q[cksb_pkg::IDX_W-1:0]] <= DW'(ah);
								value_q      <= 16'(cnt_q);
								cnt_q        <= cnt_q + cksb_pkg::CNT_W'(1);
								psprite_q    <= cnt_q[cksb_pkg::IDX_W-1:0];
								fill_q       <= 1'b0;
								phase_last_q <= '0;
								rect0_q      <= '{x0: '0, y0: '0, w: DW'(aw), h: DW'(ah)};
								state_q      <= S_PSTART;
							end
						end
						cksb_pkg::MODE_CLEAR: begin
							cnt_q <= '0;
						end
						cksb_pkg::MODE_FILL: begin
							if (bad_t) begin
								status_q <= cksb_pkg::ST_BAD;
							end else begin
								if (fill_sat) status_q <= cksb_pkg::ST_SAT;
								width_q[tgt_q]  <= DW'(nw);
								height_q[tgt_q] <= DW'(nh);
								psprite_q    <= tgt_q;
								fill_q       <= 1'b1;
								phase_last_q <= PH_USER;
								// new columns of old rows, new rows, then the rectangle
								rect0_q <= '{x0: tw_q, y0: '0, w: DW'(nw - tw), h: th_q};
								rect1_q <= '{x0: '0, y0: th_q, w: DW'(nw), h: DW'(nh - th)};
								rect2_q <= '{x0: DW'(xc), y0: DW'(yc), w: DW'(wv), h: DW'(hv)};
								state_q <= S_PSTART;
							end
						end
						cksb_pkg::MODE_BLIT: begin
							if (bad_t || bad_s) begin
								status_q <= cksb_pkg::ST_BAD;
							end else begin
								rect0_q <= '{x0: DW'(c0), y0: DW'(r0), w: DW'(nc), h: DW'(nr)};
								state_q <= S_BSTART;
							end
						end
						cksb_pkg::MODE_READ: begin
							if (bad_t) begin
								status_q <= cksb_pkg::ST_BAD;
							end else if (in_rng) begin
								state_q <= S_RWAIT;
							end else begin
								value_q <= cksb_pkg::KEY_COLOR;
							end
						end
						default: begin
						end
					endcase
				end
				S_PSTART: begin
					state_q <= S_PRUN;
				end
				S_PRUN: begin
					if (wpos.empty || wpos.last) begin
						if (phase_q == phase_last_q) begin
							state_q <= S_OUT;
						end else begin
							phase_q <= phase_q + 2'd1;
							state_q <= S_PSTART;
						end
					end
				end
				S_BSTART: begin
					state_q <= S_BRD;
				end
				S_BRD: begin
					state_q <= wpos.empty ? S_OUT : S_BWR;
				end
				S_BWR: begin
					state_q <= wpos.last ? S_OUT : S_BRD;
				end
				S_RWAIT: begin
					value_q <= rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = (state_q == S_OUT);
	assign status       = status_q;
	assign value        = value_q;
	assign sprite_count = cnt_q;

endmodule

// File: test/cksb_checker.sv
// Checker for the sprite blitter: predicts each command's result and compares it.
`timescale 1ns / 1ps
module cksb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  target_sprite,
	input  logic [2:0]  source_sprite,
	input  logic [8:0]  pos_x,
	input  logic [8:0]  pos_y,
	input  logic [8:0]  rect_w,
	input  logic [8:0]  rect_h,
	input  logic [15:0] color,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [15:0] value,
	input  logic [3:0]  sprite_count,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	localparam int REGION = cksb_pkg::MAX_WIDTH * cksb_pkg::MAX_HEIGHT;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] value;
		logic [3:0]  count;
	} cmd_result_t;

	// shadow copy of the sprite store
	logic [15:0] pix [0:cksb_pkg::MAX_SPRITES*REGION-1];
	int sw [cksb_pkg::MAX_SPRITES];
	int sh [cksb_pkg::MAX_SPRITES];
	int n_defined;
	cmd_result_t result_q [$];

	assign pending = result_q.size();

	function automatic int pix_addr(int s, int r, int c);
		return s * REGION + r * cksb_pkg::MAX_WIDTH + c;
	endfunction

	function automatic void paint(int s, int x0, int y0, int w, int h, logic [15:0] c);
		for (int r = 0; r < h; r++)
			for (int k = 0; k < w; k++)
				pix[pix_addr(s, y0 + r, x0 + k)] = c;
	endfunction

	// work out the result of one command and update the shadow state
	function automatic cmd_result_t run_command(logic [2:0] m, int tgt, int src,
			int x, int y, int w, int h, logic [15:0] c);
		cmd_result_t res;
		int s, nw, nh, r0, c0, r1, c1;
		logic [15:0] p;
		res = '0;
		res.status = cksb_pkg::ST_OK;
		case (m)
			cksb_pkg::MODE_ADD: begin
				if (n_defined >= cksb_pkg::MAX_SPRITES) begin
					res.status = cksb_pkg::ST_FULL;
				end else begin
					s = n_defined;
					if (w < 0) w = 0;
					if (h < 0) h = 0;
					if (w > cksb_pkg::MAX_WIDTH) begin
						w = cksb_pkg::MAX_WIDTH;
						res.status = cksb_pkg::ST_SAT;
					end
					if (h > cksb_pkg::MAX_HEIGHT) begin
						h = cksb_pkg::MAX_HEIGHT;
						res.status = cksb_pkg::ST_SAT;
					end
					sw[s] = w;
					sh[s] = h;
					paint(s, 0, 0, w, h, cksb_pkg::KEY_COLOR);
					n_defined = s + 1;
					res.value = 16'(s);
				end
			end
			cksb_pkg::MODE_CLEAR: n_defined = 0;
			cksb_pkg::MODE_FILL: begin
				if (tgt >= n_defined) begin
					res.status = cksb_pkg::ST_BAD;
				end else begin
					if (x < 0) x = 0;
					if (x > sw[tgt]) x = sw[tgt];
					if (y < 0) y = 0;
					if (y > sh[tgt]) y = sh[tgt];
					if (w == -1) w = sw[tgt] - x;
					else if (w < 0) w = 0;
					if (h == -1) h = sh[tgt] - y;
					else if (h < 0) h = 0;
					nw = (x + w > sw[tgt]) ? x + w : sw[tgt];
					nh = (y + h > sh[tgt]) ? y + h : sh[tgt];
					if (nw > cksb_pkg::MAX_WIDTH) begin
						nw = cksb_pkg::MAX_WIDTH;
						res.status = cksb_pkg::ST_SAT;
					end
					if (nh > cksb_pkg::MAX_HEIGHT) begin
						nh = cksb_pkg::MAX_HEIGHT;
						res.status = cksb_pkg::ST_SAT;
					end
					if (x + w > nw) w = nw - x;
					if (y + h > nh) h = nh - y;
					// grown area turns transparent before the fill lands
					paint(tgt, sw[tgt], 0, nw - sw[tgt], sh[tgt], cksb_pkg::KEY_COLOR);
					paint(tgt, 0, sh[tgt], nw, nh - sh[tgt], cksb_pkg::KEY_COLOR);
					sw[tgt] = nw;
					sh[tgt] = nh;
					paint(tgt, x, y, w, h, c);
				end
			end
			cksb_pkg::MODE_BLIT: begin
				if (tgt >= n_defined || src >= n_defined) begin
					res.status = cksb_pkg::ST_BAD;
				end else begin
					r0 = (y < 0) ? -y : 0;
					c0 = (x < 0) ? -x : 0;
					r1 = sh[src];
					c1 = sw[src];
					if (r1 + y > sh[tgt]) r1 = sh[tgt] - y;
					if (c1 + x > sw[tgt]) c1 = sw[tgt] - x;
					// in place, row by row, so a self blit sees its own writes
					for (int r = r0; r < r1; r++)
						for (int k = c0; k < c1; k++) begin
							p = pix[pix_addr(src, r, k)];
							if (p != cksb_pkg::KEY_COLOR) pix[pix_addr(tgt, y + r, x + k)] = p;
						end
				end
			end
			cksb_pkg::MODE_READ: begin
				if (tgt >= n_defined) res.status = cksb_pkg::ST_BAD;
				else if (x >= 0 && y >= 0 && x < sw[tgt] && y < sh[tgt])
					res.value = pix[pix_addr(tgt, y, x)];
				else
					res.value = cksb_pkg::KEY_COLOR;
			end
			default: ;
		endcase
		res.count = 4'(n_defined);
		return res;
	endfunction

	// input side: predict every accepted command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_defined = 0;
			for (int i = 0; i < cksb_pkg::MAX_SPRITES; i++) begin
				sw[i] = 0;
				sh[i] = 0;
			end
		end else if (in_valid && !in_stall) begin
			result_q.push_back(run_command(mode, target_sprite, source_sprite,
				$signed(pos_x), $signed(pos_y), $signed(rect_w), $signed(rect_h), color));
		end
	end

	// output side: compare every accepted result with the oldest prediction
	initial begin
		fail_count = 0;
		checked = 0;
	end
	always @(posedge clk) begin
		cmd_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("result transaction with no command waiting");
				fail_count++;
			end else begin
				exp_res = result_q.pop_front();
				checked++;
				if (status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, status);
					fail_count++;
				end
				if (value !== exp_res.value) begin
					$error("value: expected %h, actual %h", exp_res.value, value);
					fail_count++;
				end
				if (sprite_count !== exp_res.count) begin
					$error("sprite_count: expected %0d, actual %0d", exp_res.count,
						sprite_count);
					fail_count++;
				end
			end
		end
	end

endmodule

// File: test/tb_color_keyed_sprite_blitter_top.sv
// Testbench top for the sprite blitter: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module tb_color_keyed_sprite_blitter_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [2:0]  target_sprite = '0;
	logic [2:0]  source_sprite = '0;
	logic [8:0]  pos_x = '0;
	logic [8:0]  pos_y = '0;
	logic [8:0]  rect_w = '0;
	logic [8:0]  rect_h = '0;
	logic [15:0] color = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] value;
	logic [3:0]  sprite_count;

	int fail_count, pending, checked;
	int tx_idle = 23;
	int rx_idle = 66;
	int n_sent = 0;
	int n_live = 0;   // rough sprite count, only to aim indices

	color_keyed_sprite_blitter_top dut (.*);

	cksb_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle);

	// one command transaction, with random idle cycles ahead of it
	task automatic send(logic [2:0] m, int tgt, int src, int x, int y, int w, int h,
			int c);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		target_sprite <= tgt[2:0];
		source_sprite <= src[2:0];
		pos_x         <= x[8:0];
		pos_y         <= y[8:0];
		rect_w        <= w[8:0];
		rect_h        <= h[8:0];
		color         <= c[15:0];
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (m == cksb_pkg::MODE_ADD && n_live < cksb_pkg::MAX_SPRITES) n_live++;
		if (m == cksb_pkg::MODE_CLEAR) n_live = 0;
	endtask

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5) return $signed($urandom_range(511) & 9'h1FF) << 23 >>> 23;
		if (roll < 12) return -1;
		if (roll < 16) return -int'($urandom_range(2, 256));
		return $urandom_range(0, 12);
	endfunction

	function automatic int pick_pos();
		if ($urandom_range(99) < 20) return int'($urandom_range(511)) - 256;
		return int'($urandom_range(0, 20)) - 4;
	endfunction

	task automatic random_command();
		int roll, tgt, src;
		logic [2:0] m;
		roll = $urandom_range(99);
		if (roll < 20) m = cksb_pkg::MODE_ADD;
		else if (roll < 25) m = cksb_pkg::MODE_CLEAR;
		else if (roll < 55) m = cksb_pkg::MODE_FILL;
		else if (roll < 75) m = cksb_pkg::MODE_BLIT;
		else if (roll < 95) m = cksb_pkg::MODE_READ;
		else m = 3'($urandom_range(5, 7));
		tgt = (n_live > 0 && $urandom_range(9) != 0) ? $urandom_range(0, n_live - 1)
			: $urandom_range(7);
		src = (n_live > 0 && $urandom_range(9) != 0) ? $urandom_range(0, n_live - 1)
			: $urandom_range(7);
		send(m, tgt, src, pick_pos(), pick_pos(), pick_size(), pick_size(),
			$urandom_range(65535));
	endtask

	// time limit
	initial begin
		#400000000;
		$display("tb_color_keyed_sprite_blitter_top failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: size corner cases, growth, clipping, key skip, bad indices
		send(cksb_pkg::MODE_ADD, 0, 0, 0, 0, -1, -1, 0);
		send(cksb_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0);
		send(cksb_pkg::MODE_ADD, 0, 0, 0, 0, 4, 3, 0);
		send(cksb_pkg::MODE_ADD, 0, 0, 0, 0, 255, 2, 0);
		send(cksb_pkg::MODE_FILL, 1, 0, -3, -2, -1, -1, 16'h1234);
		send(cksb_pkg::MODE_FILL, 1, 0, 2, 1, 5, 4, 16'hABCD);
		send(cksb_pkg::MODE_FILL, 0, 0, 0, 0, -5, 3, 16'hFFFF);
		send(cksb_pkg::MODE_FILL, 2, 0, 100, 0, 255, 1, 16'h0000);
		send(cksb_pkg::MODE_READ, 1, 0, 6, 4, 0, 0, 0);
		send(cksb_pkg::MODE_READ, 1, 0, 0, 4, 0, 0, 0);
		send(cksb_pkg::MODE_READ, 1, 0, -1, 0, 0, 0, 0);
		send(cksb_pkg::MODE_READ, 1, 0, 255, -256, 0, 0, 0);
		send(cksb_pkg::MODE_FILL, 1, 0, 0, 0, 2, 2, cksb_pkg::KEY_COLOR);
		send(cksb_pkg::MODE_BLIT, 2, 1, -1, -1, 0, 0, 0);
		send(cksb_pkg::MODE_BLIT, 1, 1, 1, 0, 0, 0, 0);
		send(cksb_pkg::MODE_BLIT, 1, 2, -256, 255, 0, 0, 0);
		send(cksb_pkg::MODE_READ, 2, 0, 3, 1, 0, 0, 0);
		send(cksb_pkg::MODE_BLIT, 1, 7, 0, 0, 0, 0, 0);
		send(cksb_pkg::MODE_FILL, 5, 0, 0, 0, 1, 1, 1);
		send(cksb_pkg::MODE_READ, 3, 0, 0, 0, 0, 0, 0);
		for (int m = 5; m <= 7; m++) send(3'(m), 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send(cksb_pkg::MODE_ADD, 0, 0, 0, 0, i, 255 - 250 + i, 0);
		send(cksb_pkg::MODE_READ, 7, 0, 0, 0, 0, 0, 0);
		send(cksb_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send(cksb_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0);

		// random commands over three idling phases
		for (int i = 0; i < 69; i++) begin
			if (i == 23) begin
				tx_idle = 66;
				rx_idle = 23;
			end
			if (i == 46) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			random_command();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d commands (directed corners, then random mixes of add, clear,",
			n_sent);
		$display("fill, blit, read and unused modes); %0d results checked.", checked);
		if (fail_count == 0)
			$display("tb_color_keyed_sprite_blitter_top passed");
		else
			$display("tb_color_keyed_sprite_blitter_top failed");
		$finish;
	end

endmodule
